// ----- hdl/i2cmts_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Shared types and constants for the i2c master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  // operation codes carried on in_tuser
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;
  localparam logic [1:0] OP_SUPPLY = 2'd3;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // bus phase codes
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START      = 4'd1,
    PH_TX_LOW     = 4'd2,
    PH_TX_HIGH    = 4'd3,
    PH_TXACK_LOW  = 4'd4,
    PH_TXACK_HIGH = 4'd5,
    PH_RX_LOW     = 4'd6,
    PH_RX_HIGH    = 4'd7,
    PH_RXACK_LOW  = 4'd8,
    PH_RXACK_HIGH = 4'd9,
    PH_WAIT       = 4'd10,
    PH_STOP_A     = 4'd11,
    PH_STOP_B     = 4'd12,
    PH_STOP_C     = 4'd13
  } phase_t;

  // sequencer state
  typedef struct packed {
    phase_t     phase;
    logic       is_read;
    logic [3:0] bit_cnt;
    logic [7:0] shift;
    logic [7:0] bytes_done;
    logic [7:0] bytes_wanted;
    logic [7:0] pending_byte;
    logic       pending_valid;
    logic       address_ack;
  } seq_state_t;

  // one input word
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] address;
    logic [7:0] length;
    logic [7:0] data_byte;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  // one result word
  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       need_byte;
    logic       done_res;
    logic [7:0] byte_count;
    logic       addr_acked;
  } result_t;

endpackage

// ----- hdl/i2c_master_transfer_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_unit
// I2C master that runs one transfer per begin word, at most one bit phase per tick.
// ----------------------------------------------------------------------------
// Each input word (tick, begin read, begin write or supply byte) produces one
// result word holding the SCL/SDA drives for the next phase plus status. The
// block sustains one word per clock while the output is being taken; a word is
// latched in an input register, evaluated by the phase logic and moves into the
// output register once that register is empty or being taken. Input is stalled
// only while both registers are full and the output is not being taken.
module i2c_master_transfer_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // address[7:0], length[15:8], data_byte[23:16], scl_in[24], sda_in[25], zero pad
  input  logic [31:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_low[0], sda_low[1], rx_byte[9:2], rx_valid[10], need_byte[11],
  // done_res[12], byte_count[20:13], addr_acked[21], zero pad
  output logic [23:0] out_tdata
);

  logic                   in_valid_r;
  i2cmts_pkg::item_t      in_item_r;
  logic                   out_valid_r;
  i2cmts_pkg::result_t    out_res_r;
  i2cmts_pkg::seq_state_t st_r;
  i2cmts_pkg::seq_state_t st_nxt;
  i2cmts_pkg::result_t    res_nxt;
  logic                   adv;
  logic                   in_fire;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.operation <= in_tuser;
      in_item_r.address   <= in_tdata[7:0];
      in_item_r.length    <= in_tdata[15:8];
      in_item_r.data_byte <= in_tdata[23:16];
      in_item_r.scl_in    <= in_tdata[24];
      in_item_r.sda_in    <= in_tdata[25];
    end
  end

  // phase logic
  i2cmts_step u_step (
    .st     (st_r),
    .item   (in_item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // sequencer state, committed when a word moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: i2cmts_pkg::PH_IDLE, default: '0};
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.addr_acked, out_res_r.byte_count,
                       out_res_r.done_res, out_res_r.need_byte, out_res_r.rx_valid,
                       out_res_r.rx_byte, out_res_r.sda_low, out_res_r.scl_low};

  // a completed stop leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res_nxt.done_res) |=> (st_r.phase == i2cmts_pkg::PH_IDLE))
    else $error("stop completed but sequencer not idle");

  // input stalls only behind a full, blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a blocked output");

  // a pending write byte never survives into a read transfer
  a_pending_write: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pending_valid |-> !st_r.is_read)
    else $error("pending byte during read transfer");

endmodule

// ----- hdl/i2cmts_step.sv -----
// ----------------------------------------------------------------------------
// i2cmts_step
// Next-state and line-drive logic for one word of the transfer sequencer.
// ----------------------------------------------------------------------------
module i2cmts_step (
  input  i2cmts_pkg::seq_state_t st,
  input  i2cmts_pkg::item_t      item,
  output i2cmts_pkg::seq_state_t st_nxt,
  output i2cmts_pkg::result_t    res
);

  logic       active;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       done;
  logic [3:0] cnt_inc;
  logic [7:0] done_inc;
  logic       last_byte;
  logic       all_done;
  logic       all_done_inc;

  assign active   = (st.phase >= i2cmts_pkg::PH_START) && (st.phase <= i2cmts_pkg::PH_STOP_C);
  assign cnt_inc  = st.bit_cnt + 4'd1;
  assign done_inc = st.bytes_done + 8'd1;
  assign all_done     = (st.bytes_done == st.bytes_wanted);
  assign all_done_inc = (done_inc == st.bytes_wanted);

  // state transition
  always_comb begin
    st_nxt   = st;
    rx_valid = 1'b0;
    rx_byte  = 8'd0;
    done     = 1'b0;
    case (item.operation)
      i2cmts_pkg::OP_READ, i2cmts_pkg::OP_WRITE: begin
        if (!active) begin
          st_nxt.is_read       = (item.operation == i2cmts_pkg::OP_READ);
          st_nxt.shift         = item.address;
          st_nxt.bytes_wanted  = item.length;
          st_nxt.bit_cnt       = 4'd0;
          st_nxt.bytes_done    = 8'd0;
          st_nxt.pending_valid = 1'b0;
          st_nxt.address_ack   = 1'b0;
          st_nxt.phase         = i2cmts_pkg::PH_START;
        end
      end
      i2cmts_pkg::OP_SUPPLY: begin
        if (active && !st.is_read) begin
          st_nxt.pending_byte  = item.data_byte;
          st_nxt.pending_valid = 1'b1;
        end
      end
      default: begin
        case (st.phase)
          i2cmts_pkg::PH_START: begin
            st_nxt.bit_cnt = 4'd0;
            st_nxt.phase   = i2cmts_pkg::PH_TX_LOW;
          end
          i2cmts_pkg::PH_TX_LOW: st_nxt.phase = i2cmts_pkg::PH_TX_HIGH;
          i2cmts_pkg::PH_TX_HIGH: begin
            if (item.scl_in) begin
              st_nxt.shift   = {st.shift[6:0], 1'b0};
              st_nxt.bit_cnt = cnt_inc;
              st_nxt.phase   = (cnt_inc >= i2cmts_pkg::BITS_PER_BYTE) ?
                               i2cmts_pkg::PH_TXACK_LOW : i2cmts_pkg::PH_TX_LOW;
            end
          end
          i2cmts_pkg::PH_TXACK_LOW: st_nxt.phase = i2cmts_pkg::PH_TXACK_HIGH;
          i2cmts_pkg::PH_TXACK_HIGH: begin
            if (item.scl_in) begin
              if (item.sda_in) begin
                st_nxt.phase = i2cmts_pkg::PH_STOP_A;
              end else if (!st.address_ack && st.is_read) begin
                // address acked, first read byte
                st_nxt.address_ack = 1'b1;
                if (all_done) begin
                  st_nxt.phase = i2cmts_pkg::PH_STOP_A;
                end else begin
                  st_nxt.shift   = 8'd0;
                  st_nxt.bit_cnt = 4'd0;
                  st_nxt.phase   = i2cmts_pkg::PH_RX_LOW;
                end
              end else begin
                // address or data byte acked on a write
                st_nxt.address_ack = 1'b1;
                if (st.address_ack) begin
                  st_nxt.bytes_done = done_inc;
                end
                if (st.address_ack ? all_done_inc : all_done) begin
                  st_nxt.phase = i2cmts_pkg::PH_STOP_A;
                end else if (st.pending_valid) begin
                  st_nxt.shift         = st.pending_byte;
                  st_nxt.pending_valid = 1'b0;
                  st_nxt.bit_cnt       = 4'd0;
                  st_nxt.phase         = i2cmts_pkg::PH_TX_LOW;
                end else begin
                  st_nxt.phase = i2cmts_pkg::PH_WAIT;
                end
              end
            end
          end
          i2cmts_pkg::PH_WAIT: begin
            if (all_done) begin
              st_nxt.phase = i2cmts_pkg::PH_STOP_A;
            end else if (st.pending_valid) begin
              st_nxt.shift         = st.pending_byte;
              st_nxt.pending_valid = 1'b0;
              st_nxt.bit_cnt       = 4'd0;
              st_nxt.phase         = i2cmts_pkg::PH_TX_LOW;
            end
          end
          i2cmts_pkg::PH_RX_LOW: st_nxt.phase = i2cmts_pkg::PH_RX_HIGH;
          i2cmts_pkg::PH_RX_HIGH: begin
            if (item.scl_in) begin
              st_nxt.shift   = {st.shift[6:0], item.sda_in};
              st_nxt.bit_cnt = cnt_inc;
              st_nxt.phase   = (cnt_inc >= i2cmts_pkg::BITS_PER_BYTE) ?
                               i2cmts_pkg::PH_RXACK_LOW : i2cmts_pkg::PH_RX_LOW;
            end
          end
          i2cmts_pkg::PH_RXACK_LOW: st_nxt.phase = i2cmts_pkg::PH_RXACK_HIGH;
          i2cmts_pkg::PH_RXACK_HIGH: begin
            if (item.scl_in) begin
              rx_valid          = 1'b1;
              rx_byte           = st.shift;
              st_nxt.bytes_done = done_inc;
              if (all_done_inc) begin
                st_nxt.phase = i2cmts_pkg::PH_STOP_A;
              end else begin
                st_nxt.shift   = 8'd0;
                st_nxt.bit_cnt = 4'd0;
                st_nxt.phase   = i2cmts_pkg::PH_RX_LOW;
              end
            end
          end
          i2cmts_pkg::PH_STOP_A: st_nxt.phase = i2cmts_pkg::PH_STOP_B;
          i2cmts_pkg::PH_STOP_B: st_nxt.phase = i2cmts_pkg::PH_STOP_C;
          i2cmts_pkg::PH_STOP_C: begin
            if (item.scl_in) begin
              st_nxt.phase = i2cmts_pkg::PH_IDLE;
              done         = 1'b1;
            end
          end
          default: st_nxt.phase = i2cmts_pkg::PH_IDLE;
        endcase
      end
    endcase
  end

  // ack/nack choice for a received byte, from the updated count
  assign last_byte = ({1'b0, st_nxt.bytes_done} + 9'd1) >= {1'b0, st_nxt.bytes_wanted};

  // line drives for the phase that follows
  always_comb begin
    res            = '0;
    res.rx_byte    = rx_byte;
    res.rx_valid   = rx_valid;
    res.done_res   = done;
    res.byte_count = st_nxt.bytes_done;
    res.addr_acked = st_nxt.address_ack;
    res.need_byte  = (st_nxt.phase == i2cmts_pkg::PH_WAIT) && !st_nxt.pending_valid;
    case (st_nxt.phase)
      i2cmts_pkg::PH_START: res.sda_low = 1'b1;
      i2cmts_pkg::PH_TX_LOW: begin
        res.scl_low = 1'b1;
        res.sda_low = ((st_nxt.shift & i2cmts_pkg::MSB_MASK) == 8'd0);
      end
      i2cmts_pkg::PH_TX_HIGH: res.sda_low = ((st_nxt.shift & i2cmts_pkg::MSB_MASK) == 8'd0);
      i2cmts_pkg::PH_TXACK_LOW, i2cmts_pkg::PH_RX_LOW,
      i2cmts_pkg::PH_WAIT, i2cmts_pkg::PH_STOP_A: res.scl_low = 1'b1;
      i2cmts_pkg::PH_RXACK_LOW: begin
        res.scl_low = 1'b1;
        res.sda_low = !last_byte;
      end
      i2cmts_pkg::PH_RXACK_HIGH: res.sda_low = !last_byte;
      i2cmts_pkg::PH_STOP_B: begin
        res.scl_low = 1'b1;
        res.sda_low = 1'b1;
      end
      i2cmts_pkg::PH_STOP_C: res.sda_low = 1'b1;
      default: begin
        res.scl_low = 1'b0;
        res.sda_low = 1'b0;
      end
    endcase
  end

endmodule
